// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the pose integrator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DRPI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pose integrator assertion failed");
`define DRPI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pose integrator assertion failed");
`else
`define DRPI_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DRPI_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/drpi_pkg.sv -----
// Types, constants and the arctangent table of the pose integrator.
package drpi_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_IDX_W       = 5;
    localparam int CFG_IDX_W        = 1;
    localparam int CFG_DATA_W       = 16;
    localparam int XY_W             = 38;
    localparam int ANG_W            = 34;

    localparam logic [9:0]  SPIKE_RATIO_RST    = 10'd435;
    localparam logic [15:0] HEADING_OFFSET_RST = 16'd16384;
    localparam logic signed [XY_W-1:0] CORDIC_START = 38'sd652032874;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPIKE_RATIO    = 1'b0,
        CFG_HEADING_OFFSET = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ACT_SPEED  = 2'd0,
        ACT_ORIENT = 2'd1,
        ACT_TICK   = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_VEL,
        OP_QMUL,
        OP_VEC_INIT,
        OP_VEC_ITER,
        OP_YAW,
        OP_ROT_INIT,
        OP_ROT_ITER,
        OP_MUL_C,
        OP_MUL_S,
        OP_LO_X,
        OP_HI_X,
        OP_POS_X,
        OP_LO_Y,
        OP_HI_Y,
        OP_POS_Y,
        OP_EMIT
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_VEL,
        ST_QMUL,
        ST_VEC_INIT,
        ST_VEC_ITER,
        ST_YAW,
        ST_ROT_INIT,
        ST_ROT_ITER,
        ST_MUL_C,
        ST_MUL_S,
        ST_LO_X,
        ST_HI_X,
        ST_POS_X,
        ST_LO_Y,
        ST_HI_Y,
        ST_POS_Y,
        ST_EMIT
    } state_t;

    typedef struct packed {
        op_t                   op;
        logic [ATAN_IDX_W-1:0] step;
    } drpi_cmd_t;

    typedef struct packed {
        logic out_free;
    } drpi_status_t;

    // atan(2^-i) as a binary angle, 2^32 per full turn
    function automatic logic [31:0] atan_entry(input logic [ATAN_IDX_W-1:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0:    r = 32'h20000000;
                5'd1:    r = 32'h12E4051E;
                5'd2:    r = 32'h09FB385B;
                5'd3:    r = 32'h051111D4;
                5'd4:    r = 32'h028B0D43;
                5'd5:    r = 32'h0145D7E1;
                5'd6:    r = 32'h00A2F61E;
                5'd7:    r = 32'h00517C55;
                5'd8:    r = 32'h0028BE53;
                5'd9:    r = 32'h00145F2F;
                5'd10:   r = 32'h000A2F98;
                5'd11:   r = 32'h000517CC;
                5'd12:   r = 32'h00028BE6;
                5'd13:   r = 32'h000145F3;
                5'd14:   r = 32'h0000A2FA;
                5'd15:   r = 32'h0000517D;
                5'd16:   r = 32'h000028BE;
                5'd17:   r = 32'h0000145F;
                5'd18:   r = 32'h00000A30;
                5'd19:   r = 32'h00000518;
                5'd20:   r = 32'h0000028C;
                5'd21:   r = 32'h00000146;
                5'd22:   r = 32'h000000A3;
                5'd23:   r = 32'h00000051;
                default: r = 32'h00000000;
            endcase
            return r;
        end
    endfunction

endpackage

// ----- hw/rtl/drpi_in_if.sv -----
// Request channel carrying sensor samples and integration ticks.
interface drpi_in_if;
    logic                     valid;
    logic                     ready;
    drpi_pkg::action_t        action;
    logic signed [15:0]       velocity;
    logic signed [15:0]       quat_w;
    logic signed [15:0]       quat_x;
    logic signed [15:0]       quat_y;
    logic signed [15:0]       quat_z;
    logic [15:0]              elapsed;

    modport source (output valid, action, velocity, quat_w, quat_x, quat_y, quat_z, elapsed,
                    input ready);
    modport sink (input valid, action, velocity, quat_w, quat_x, quat_y, quat_z, elapsed,
                  output ready);
endinterface

// ----- hw/rtl/drpi_out_if.sv -----
// Result channel carrying the integrated pose.
interface drpi_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] position_x;
    logic signed [47:0] position_y;
    logic signed [15:0] speed_x;
    logic signed [15:0] speed_y;
    logic [15:0]        heading_angle;

    modport source (output valid, position_x, position_y, speed_x, speed_y, heading_angle,
                    input ready);
    modport sink (input valid, position_x, position_y, speed_x, speed_y, heading_angle,
                  output ready);
endinterface

// ----- hw/rtl/drpi_ctrl.sv -----
// Sequencer of the pose integrator: walks each request through the datapath.
module drpi_ctrl #(
    parameter int CORDIC_STEPS = drpi_pkg::CORDIC_STEPS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  drpi_pkg::action_t      in_action,
    output logic                   in_ready,
    output drpi_pkg::drpi_cmd_t    cmd,
    input  drpi_pkg::drpi_status_t status
);
    import drpi_pkg::*;

    localparam int CNT_W = $clog2(CORDIC_STEPS);
    localparam logic [CNT_W-1:0] ITER_LAST = CNT_W'(CORDIC_STEPS - 1);
    localparam logic [CNT_W-1:0] QMUL_LAST = CNT_W'(3);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        cmd.op     = OP_NONE;
        cmd.step   = ATAN_IDX_W'(cnt_reg);
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cnt_next = '0;
                if (in_valid)
                begin
                    cmd.op = OP_LOAD;
                    unique case (in_action)
                        ACT_SPEED:  state_next = ST_VEL;
                        ACT_ORIENT: state_next = ST_QMUL;
                        ACT_TICK:   state_next = ST_ROT_INIT;
                        ACT_NONE:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_VEL:
            begin
                cmd.op     = OP_VEL;
                state_next = ST_IDLE;
            end
            ST_QMUL:
            begin
                cmd.op = OP_QMUL;
                if (cnt_reg == QMUL_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_VEC_INIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_VEC_INIT:
            begin
                cmd.op     = OP_VEC_INIT;
                state_next = ST_VEC_ITER;
            end
            ST_VEC_ITER:
            begin
                cmd.op = OP_VEC_ITER;
                if (cnt_reg == ITER_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_YAW;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_YAW:
            begin
                cmd.op     = OP_YAW;
                state_next = ST_IDLE;
            end
            ST_ROT_INIT:
            begin
                cmd.op     = OP_ROT_INIT;
                state_next = ST_ROT_ITER;
            end
            ST_ROT_ITER:
            begin
                cmd.op = OP_ROT_ITER;
                if (cnt_reg == ITER_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_MUL_C;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_MUL_C:
            begin
                cmd.op     = OP_MUL_C;
                state_next = ST_MUL_S;
            end
            ST_MUL_S:
            begin
                cmd.op     = OP_MUL_S;
                state_next = ST_LO_X;
            end
            ST_LO_X:
            begin
                cmd.op     = OP_LO_X;
                state_next = ST_HI_X;
            end
            ST_HI_X:
            begin
                cmd.op     = OP_HI_X;
                state_next = ST_POS_X;
            end
            ST_POS_X:
            begin
                cmd.op     = OP_POS_X;
                state_next = ST_LO_Y;
            end
            ST_LO_Y:
            begin
                cmd.op     = OP_LO_Y;
                state_next = ST_HI_Y;
            end
            ST_HI_Y:
            begin
                cmd.op     = OP_HI_Y;
                state_next = ST_POS_Y;
            end
            ST_POS_Y:
            begin
                cmd.op     = OP_POS_Y;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // hold until the output register can take the pose
                if (status.out_free)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/drpi_datapath.sv -----
// Datapath of the pose integrator: shared CORDIC, shared multiplier, pose state.
module drpi_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  drpi_pkg::drpi_cmd_t             cmd,
    output drpi_pkg::drpi_status_t          status,
    input  logic                            cfg_we,
    input  logic [drpi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [drpi_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic signed [15:0]              in_velocity,
    input  logic signed [15:0]              in_quat_w,
    input  logic signed [15:0]              in_quat_x,
    input  logic signed [15:0]              in_quat_y,
    input  logic signed [15:0]              in_quat_z,
    input  logic [15:0]                     in_elapsed,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [47:0]              out_position_x,
    output logic signed [47:0]              out_position_y,
    output logic signed [15:0]              out_speed_x,
    output logic signed [15:0]              out_speed_y,
    output logic [15:0]                     out_heading_angle
);
    import drpi_pkg::*;

    localparam logic signed [ANG_W-1:0] ANG_HALF  = 34'sd2147483648;
    localparam logic signed [ANG_W-1:0] ANG_QUART = 34'sd1073741824;
    localparam logic signed [33:0]      DEN_ONE   = 34'sd268435456;
    localparam logic signed [65:0]      HALF_LSB  = 66'sd536870912;

    function automatic logic signed [15:0] round_sat16(input logic signed [48:0] v);
        logic signed [48:0] s;
        logic signed [18:0] r;
        begin
            s = v + 49'sd536870912;
            r = s[48:30];
            if (r > 19'sd32767)
                return 16'sh7FFF;
            else if (r < -19'sd32768)
                return 16'sh8000;
            else
                return r[15:0];
        end
    endfunction

    function automatic logic signed [47:0] add_sat48(input logic signed [47:0] p,
                                                     input logic signed [35:0] d);
        logic signed [48:0] s;
        begin
            s = 49'(p) + 49'(d);
            if (s[48] != s[47])
                return s[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
            else
                return s[47:0];
        end
    endfunction

    // configuration and architectural state
    logic [9:0]          ratio_reg, ratio_next;
    logic [15:0]         offset_reg, offset_next;
    logic                seen_reg, seen_next;
    logic signed [15:0]  prev_reg, prev_next;
    logic signed [15:0]  speed_reg, speed_next;
    logic [15:0]         heading_reg, heading_next;
    logic signed [47:0]  posx_reg, posx_next;
    logic signed [47:0]  posy_reg, posy_next;
    logic                out_valid_reg, out_valid_next;

    // working registers
    logic signed [15:0]       vel_reg, qw_reg, qx_reg, qy_reg, qz_reg;
    logic [15:0]              dt_reg;
    logic signed [32:0]       acc_a_reg, acc_a_next, acc_b_reg, acc_b_next;
    logic signed [XY_W-1:0]   cx_reg, cx_next, cy_reg, cy_next;
    logic signed [ANG_W-1:0]  cz_reg, cz_next;
    logic                     skip_reg, skip_next, neg_reg, neg_next;
    logic signed [48:0]       pc_reg, pc_next, ps_reg, ps_next;
    logic [40:0]              lo_reg, lo_next;
    logic signed [65:0]       full_reg, full_next;
    logic signed [15:0]       sx_reg, sx_next, sy_reg, sy_next;
    logic signed [47:0]       opx_reg, opy_reg;
    logic signed [15:0]       osx_reg, osy_reg;
    logic [15:0]              ohd_reg;

    // shared multiplier
    logic signed [33:0]  mul_a;
    logic signed [17:0]  mul_b;
    logic signed [51:0]  mul_p;

    logic signed [XY_W-1:0]  dx, dy, c_full;
    logic signed [ANG_W-1:0] atan_ext;
    logic signed [26:0]      spike_lhs, spike_rhs;
    logic signed [33:0]      num_w, den_w;
    logic signed [ANG_W-1:0] rot_z;
    logic [31:0]             yaw_rnd;
    logic signed [65:0]      hi_ext;

    assign c_full    = neg_reg ? -cx_reg : cx_reg;
    assign dx        = cy_reg >>> cmd.step;
    assign dy        = cx_reg >>> cmd.step;
    assign atan_ext  = $signed({2'b00, atan_entry(cmd.step)});
    assign spike_lhs = $signed({{3{vel_reg[15]}}, vel_reg, 8'b0});
    assign spike_rhs = 27'(prev_reg) * $signed({17'b0, ratio_reg});
    assign num_w     = {acc_a_reg, 1'b0};
    assign den_w     = DEN_ONE - {acc_b_reg, 1'b0};
    assign rot_z     = 34'($signed({heading_reg, 16'b0}));
    assign yaw_rnd   = cz_reg[31:0] + 32'h0000_8000;
    assign hi_ext    = 66'($signed(mul_p[41:0]));
    assign mul_p     = 52'(mul_a) * 52'(mul_b);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_QMUL:
            begin
                case (cmd.step[1:0])
                    2'd0:    begin mul_a = 34'(qw_reg); mul_b = 18'(qz_reg); end
                    2'd1:    begin mul_a = 34'(qx_reg); mul_b = 18'(qy_reg); end
                    2'd2:    begin mul_a = 34'(qy_reg); mul_b = 18'(qy_reg); end
                    default: begin mul_a = 34'(qz_reg); mul_b = 18'(qz_reg); end
                endcase
            end
            OP_MUL_C:
            begin
                mul_a = c_full[33:0];
                mul_b = 18'(speed_reg);
            end
            OP_MUL_S:
            begin
                mul_a = neg_reg ? -cy_reg[33:0] : cy_reg[33:0];
                mul_b = 18'(speed_reg);
            end
            OP_LO_X:
            begin
                mul_a = $signed({10'b0, pc_reg[23:0]});
                mul_b = $signed({2'b0, dt_reg});
            end
            OP_HI_X:
            begin
                mul_a = 34'($signed(pc_reg[48:24]));
                mul_b = $signed({2'b0, dt_reg});
            end
            OP_LO_Y:
            begin
                mul_a = $signed({10'b0, ps_reg[23:0]});
                mul_b = $signed({2'b0, dt_reg});
            end
            OP_HI_Y:
            begin
                mul_a = 34'($signed(ps_reg[48:24]));
                mul_b = $signed({2'b0, dt_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        ratio_next     = ratio_reg;
        offset_next    = offset_reg;
        seen_next      = seen_reg;
        prev_next      = prev_reg;
        speed_next     = speed_reg;
        heading_next   = heading_reg;
        posx_next      = posx_reg;
        posy_next      = posy_reg;
        out_valid_next = out_valid_reg && !out_ready;
        acc_a_next     = acc_a_reg;
        acc_b_next     = acc_b_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cz_next        = cz_reg;
        skip_next      = skip_reg;
        neg_next       = neg_reg;
        pc_next        = pc_reg;
        ps_next        = ps_reg;
        lo_next        = lo_reg;
        full_next      = full_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_SPIKE_RATIO:    ratio_next  = cfg_data[9:0];
                CFG_HEADING_OFFSET: offset_next = cfg_data[15:0];
                default:            ratio_next  = ratio_reg;
            endcase
        end

        case (cmd.op)
            OP_VEL:
            begin
                if (!seen_reg || (spike_lhs < spike_rhs))
                    speed_next = vel_reg;
                seen_next = 1'b1;
                prev_next = vel_reg;
            end
            OP_QMUL:
            begin
                case (cmd.step[1:0])
                    2'd0:    acc_a_next = mul_p[32:0];
                    2'd1:    acc_a_next = acc_a_reg + mul_p[32:0];
                    2'd2:    acc_b_next = mul_p[32:0];
                    default: acc_b_next = acc_b_reg + mul_p[32:0];
                endcase
            end
            OP_VEC_INIT:
            begin
                skip_next = (num_w == '0) && (den_w == '0);
                if (den_w < 0)
                begin
                    cx_next = -XY_W'(den_w);
                    cy_next = -XY_W'(num_w);
                    cz_next = ANG_HALF;
                end
                else
                begin
                    cx_next = XY_W'(den_w);
                    cy_next = XY_W'(num_w);
                    cz_next = '0;
                end
            end
            OP_VEC_ITER:
            begin
                // drive y toward zero, accumulate the angle
                if (!skip_reg)
                begin
                    if (cy_reg > 0)
                    begin
                        cx_next = cx_reg + dx;
                        cy_next = cy_reg - dy;
                        cz_next = cz_reg + atan_ext;
                    end
                    else
                    begin
                        cx_next = cx_reg - dx;
                        cy_next = cy_reg + dy;
                        cz_next = cz_reg - atan_ext;
                    end
                end
            end
            OP_YAW:
            begin
                heading_next = yaw_rnd[31:16] + offset_reg;
            end
            OP_ROT_INIT:
            begin
                cx_next = CORDIC_START;
                cy_next = '0;
                if (rot_z > ANG_QUART)
                begin
                    cz_next  = rot_z - ANG_HALF;
                    neg_next = 1'b1;
                end
                else if (rot_z < -ANG_QUART)
                begin
                    cz_next  = rot_z + ANG_HALF;
                    neg_next = 1'b1;
                end
                else
                begin
                    cz_next  = rot_z;
                    neg_next = 1'b0;
                end
            end
            OP_ROT_ITER:
            begin
                // drive the residual angle toward zero
                if (cz_reg >= 0)
                begin
                    cx_next = cx_reg - dx;
                    cy_next = cy_reg + dy;
                    cz_next = cz_reg - atan_ext;
                end
                else
                begin
                    cx_next = cx_reg + dx;
                    cy_next = cy_reg - dy;
                    cz_next = cz_reg + atan_ext;
                end
            end
            OP_MUL_C: pc_next = mul_p[48:0];
            OP_MUL_S: ps_next = mul_p[48:0];
            OP_LO_X:
            begin
                lo_next = mul_p[40:0];
                sx_next = round_sat16(pc_reg);
            end
            OP_HI_X:  full_next = (hi_ext <<< 24) + $signed({25'b0, lo_reg}) + HALF_LSB;
            OP_POS_X: posx_next = add_sat48(posx_reg, full_reg[65:30]);
            OP_LO_Y:
            begin
                lo_next = mul_p[40:0];
                sy_next = round_sat16(ps_reg);
            end
            OP_HI_Y:  full_next = (hi_ext <<< 24) + $signed({25'b0, lo_reg}) + HALF_LSB;
            OP_POS_Y: posy_next = add_sat48(posy_reg, full_reg[65:30]);
            OP_EMIT:  out_valid_next = 1'b1;
            default:  out_valid_next = out_valid_reg && !out_ready;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg     <= SPIKE_RATIO_RST;
            offset_reg    <= HEADING_OFFSET_RST;
            seen_reg      <= 1'b0;
            prev_reg      <= '0;
            speed_reg     <= '0;
            heading_reg   <= '0;
            posx_reg      <= '0;
            posy_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ratio_reg     <= ratio_next;
            offset_reg    <= offset_next;
            seen_reg      <= seen_next;
            prev_reg      <= prev_next;
            speed_reg     <= speed_next;
            heading_reg   <= heading_next;
            posx_reg      <= posx_next;
            posy_reg      <= posy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            vel_reg <= in_velocity;
            qw_reg  <= in_quat_w;
            qx_reg  <= in_quat_x;
            qy_reg  <= in_quat_y;
            qz_reg  <= in_quat_z;
            dt_reg  <= in_elapsed;
        end
        if (cmd.op == OP_EMIT)
        begin
            opx_reg <= posx_reg;
            opy_reg <= posy_reg;
            osx_reg <= sx_reg;
            osy_reg <= sy_reg;
            ohd_reg <= heading_reg;
        end
        acc_a_reg <= acc_a_next;
        acc_b_reg <= acc_b_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        cz_reg    <= cz_next;
        skip_reg  <= skip_next;
        neg_reg   <= neg_next;
        pc_reg    <= pc_next;
        ps_reg    <= ps_next;
        lo_reg    <= lo_next;
        full_reg  <= full_next;
        sx_reg    <= sx_next;
        sy_reg    <= sy_next;
    end

    assign status.out_free   = !out_valid_reg || out_ready;
    assign out_valid         = out_valid_reg;
    assign out_position_x    = opx_reg;
    assign out_position_y    = opy_reg;
    assign out_speed_x       = osx_reg;
    assign out_speed_y       = osy_reg;
    assign out_heading_angle = ohd_reg;

endmodule

// ----- hw/rtl/dead_reckoning_pose_integrator.sv -----
// Top level of the planar dead-reckoning pose integrator.
// One request at a time: a velocity sample, an orientation sample or a tick
// is taken in idle and is walked through its states until the block is idle
// again. The datapath shares its work: the single CORDIC unit does one
// micro-rotation a cycle for both atan2 and sin/cos, and one shared 34x18
// multiplier forms the quaternion products, the speed-times-cos/sin products
// and the split velocity-times-time products. Only ticks return a result; the
// output register lets the next request enter while a pose waits to be taken.
`include "assert_macros.svh"
module dead_reckoning_pose_integrator #(
    parameter int CORDIC_STEPS = drpi_pkg::CORDIC_STEPS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [drpi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [drpi_pkg::CFG_DATA_W-1:0] cfg_data,
    drpi_in_if.sink                         in,
    drpi_out_if.source                      out
);
    import drpi_pkg::*;

    drpi_cmd_t    cmd;
    drpi_status_t status;
    logic         in_ready;

    drpi_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in.valid),
        .in_action (in.action),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .status    (status)
    );

    drpi_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_velocity       (in.velocity),
        .in_quat_w         (in.quat_w),
        .in_quat_x         (in.quat_x),
        .in_quat_y         (in.quat_y),
        .in_quat_z         (in.quat_z),
        .in_elapsed        (in.elapsed),
        .out_valid         (out.valid),
        .out_ready         (out.ready),
        .out_position_x    (out.position_x),
        .out_position_y    (out.position_y),
        .out_speed_x       (out.speed_x),
        .out_speed_y       (out.speed_y),
        .out_heading_angle (out.heading_angle)
    );

    assign in.ready = in_ready;

    `DRPI_ASSERT_NXT(a_busy_after_request, clk, rst_n, in.valid && in.ready && in.action != ACT_NONE, !in.ready)
    `DRPI_ASSERT_IMP(a_result_from_emit, clk, rst_n, $rose(out.valid), $past(cmd.op == OP_EMIT))
    `DRPI_ASSERT_IMP(a_load_on_accept, clk, rst_n, cmd.op == OP_LOAD, in.valid && in.ready)

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench of the dead-reckoning pose integrator.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import drpi_pkg::*;

    typedef struct packed {
        logic signed [47:0] px;
        logic signed [47:0] py;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic [15:0]        hdg;
    } pose_t;

    // Pose model: spike filter, CORDIC yaw, CORDIC sin/cos integration
    class pose_scoreboard;
        pose_t               pending_poses[$];
        int                  errors;
        int                  poses_checked;
        logic [9:0]          ratio;
        logic [15:0]         offset;
        bit                  have_speed;
        longint              last_raw;
        longint              speed;
        logic [15:0]         hdg;
        longint              pos_x;
        longint              pos_y;

        function new();
            ratio = SPIKE_RATIO_RST;
            offset = HEADING_OFFSET_RST;
            have_speed = 0;
            last_raw = 0;
            speed = 0;
            hdg = 0;
            pos_x = 0;
            pos_y = 0;
            errors = 0;
            poses_checked = 0;
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function longint angle_step(int i);
            longint tab[24] = '{
                'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
                'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
                'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
                'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051};
            return tab[i];
        endfunction

        function logic [31:0] vector_angle(longint yv, longint xv);
            longint a;
            longint dx;
            longint dy;
            a = 0;
            if (xv == 0 && yv == 0)
                return 0;
            if (xv < 0)
            begin
                xv = -xv;
                yv = -yv;
                a = 64'sd2147483648;
            end
            for (int i = 0; i < CORDIC_STEPS_DEF; i++)
            begin
                dx = yv >>> i;
                dy = xv >>> i;
                if (yv > 0)
                begin
                    xv += dx; yv -= dy; a += angle_step(i);
                end
                else
                begin
                    xv -= dx; yv += dy; a -= angle_step(i);
                end
            end
            return a[31:0];
        endfunction

        function void rotate(logic [31:0] ang, output longint c, output longint s);
            longint z;
            longint xv;
            longint yv;
            longint dx;
            longint dy;
            bit flip;
            z = ang;
            xv = 652032874;
            yv = 0;
            flip = 0;
            if (z >= 64'sd2147483648)
                z -= 64'sd4294967296;
            if (z > 64'sd1073741824)
            begin
                z -= 64'sd2147483648; flip = 1;
            end
            else if (z < -64'sd1073741824)
            begin
                z += 64'sd2147483648; flip = 1;
            end
            for (int i = 0; i < CORDIC_STEPS_DEF; i++)
            begin
                dx = yv >>> i;
                dy = xv >>> i;
                if (z >= 0)
                begin
                    xv -= dx; yv += dy; z -= angle_step(i);
                end
                else
                begin
                    xv += dx; yv -= dy; z += angle_step(i);
                end
            end
            c = flip ? -xv : xv;
            s = flip ? -yv : yv;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [15:0] val);
            if (idx == CFG_SPIKE_RATIO)
                ratio = val[9:0];
            else
                offset = val;
        endfunction

        function void note_request(action_t act, logic signed [15:0] vel,
                                   logic signed [15:0] qw, logic signed [15:0] qx,
                                   logic signed [15:0] qy, logic signed [15:0] qz,
                                   logic [15:0] dt);
            longint v;
            longint num;
            longint den;
            longint c;
            longint s;
            longint pc;
            longint ps;
            logic [31:0] a;
            logic [47:0] yaw;
            pose_t p;
            case (act)
                ACT_SPEED:
                begin
                    v = vel;
                    if (!have_speed)
                    begin
                        speed = v;
                        have_speed = 1;
                    end
                    else if (v * 256 < last_raw * longint'(ratio))
                        speed = v;
                    last_raw = v;
                end
                ACT_ORIENT:
                begin
                    num = 2 * (longint'(qw) * qz + longint'(qx) * qy);
                    den = (64'sd1 << 28) - 2 * (longint'(qy) * qy + longint'(qz) * qz);
                    a = vector_angle(num, den);
                    yaw = ({16'd0, a} + 48'h8000) >> 16;
                    hdg = yaw[15:0] + offset;
                end
                ACT_TICK:
                begin
                    rotate({hdg, 16'd0}, c, s);
                    pc = speed * c;
                    ps = speed * s;
                    p.sx = 16'(clamp((pc + (64'sd1 << 29)) >>> 30, -32768, 32767));
                    p.sy = 16'(clamp((ps + (64'sd1 << 29)) >>> 30, -32768, 32767));
                    pos_x = clamp(pos_x + ((pc * longint'(dt) + (64'sd1 << 29)) >>> 30),
                                  -(64'sd1 << 47), (64'sd1 << 47) - 1);
                    pos_y = clamp(pos_y + ((ps * longint'(dt) + (64'sd1 << 29)) >>> 30),
                                  -(64'sd1 << 47), (64'sd1 << 47) - 1);
                    p.px = pos_x[47:0];
                    p.py = pos_y[47:0];
                    p.hdg = hdg;
                    pending_poses.push_back(p);
                end
                default: ;
            endcase
        endfunction

        function void check_pose(pose_t got);
            pose_t exp_p;
            if (pending_poses.size() == 0)
            begin
                $display("%0t: unexpected pose %h", $time, got);
                errors++;
                return;
            end
            exp_p = pending_poses.pop_front();
            poses_checked++;
            if (got.px !== exp_p.px)
            begin
                $display("%0t: position_x expected %0d got %0d", $time, exp_p.px, got.px);
                errors++;
            end
            if (got.py !== exp_p.py)
            begin
                $display("%0t: position_y expected %0d got %0d", $time, exp_p.py, got.py);
                errors++;
            end
            if (got.sx !== exp_p.sx)
            begin
                $display("%0t: speed_x expected %0d got %0d", $time, exp_p.sx, got.sx);
                errors++;
            end
            if (got.sy !== exp_p.sy)
            begin
                $display("%0t: speed_y expected %0d got %0d", $time, exp_p.sy, got.sy);
                errors++;
            end
            if (got.hdg !== exp_p.hdg)
            begin
                $display("%0t: heading_angle expected %0d got %0d", $time, exp_p.hdg,
                         got.hdg);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    bit sender_done;
    int requests_sent;

    drpi_in_if  req_ch();
    drpi_out_if pose_ch();
    pose_scoreboard sb;

    dead_reckoning_pose_integrator uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in(req_ch.sink), .out(pose_ch.source)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic logic signed [15:0] rand_quat();
        case ($urandom_range(0, 5))
            0: return -16'sd16384;
            1: return 16'sd16384;
            2: return 16'sd0;
            3: return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        sb.write_reg(idx, val);
        @(posedge clk);
        cfg_we <= 0;
    endtask

    // Valid stays high into the next request when no idle cycles are drawn
    task automatic send(action_t act, logic signed [15:0] vel, logic signed [15:0] qw,
                        logic signed [15:0] qx, logic signed [15:0] qy,
                        logic signed [15:0] qz, logic [15:0] dt);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            req_ch.valid <= 0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1;
        req_ch.action <= act;
        req_ch.velocity <= vel;
        req_ch.quat_w <= qw;
        req_ch.quat_x <= qx;
        req_ch.quat_y <= qy;
        req_ch.quat_z <= qz;
        req_ch.elapsed <= dt;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_request(act, vel, qw, qx, qy, qz, dt);
        requests_sent++;
    endtask

    task automatic send_random();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 7)
            send(ACT_SPEED, ($urandom_range(0, 3) == 0) ? 16'($urandom)
                 : 16'($signed($urandom_range(0, 2000)) - 500), 0, 0, 0, 0, 0);
        else if (pick < 12)
            send(ACT_ORIENT, 16'($urandom), rand_quat(), rand_quat(), rand_quat(),
                 rand_quat(), 16'($urandom));
        else if (pick < 19)
            send(ACT_TICK, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom));
        else
            send(ACT_NONE, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom));
    endtask

    // Wait for every pose, then let the block finish an orientation in flight
    task automatic drain();
        req_ch.valid <= 0;
        while (sb.pending_poses.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Sink side: random stalls, with stall-free stretches
    initial
    begin
        pose_t got;
        int stall;
        pose_ch.ready = 0;
        @(posedge rst_n);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            if (stall > 0)
            begin
                pose_ch.ready <= 0;
                repeat (stall) @(posedge clk);
            end
            pose_ch.ready <= 1;
            @(posedge clk);
            while (!pose_ch.valid)
                @(posedge clk);
            got = {pose_ch.position_x, pose_ch.position_y, pose_ch.speed_x,
                   pose_ch.speed_y, pose_ch.heading_angle};
            sb.check_pose(got);
        end
    end

    initial
    begin
        sb = new();
        rst_n = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        req_ch.valid = 0;
        req_ch.action = ACT_SPEED;
        req_ch.velocity = 0;
        req_ch.quat_w = 0;
        req_ch.quat_x = 0;
        req_ch.quat_y = 0;
        req_ch.quat_z = 0;
        req_ch.elapsed = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: tick before any speed, first speed, spike reject, extremes
        send(ACT_TICK, 0, 0, 0, 0, 0, 16'hFFFF);
        send(ACT_SPEED, 16'sd256, 0, 0, 0, 0, 0);
        send(ACT_SPEED, 16'sd1000, 0, 0, 0, 0, 0);
        send(ACT_TICK, 0, 0, 0, 0, 0, 16'd1000);
        send(ACT_SPEED, 16'sd300, 0, 0, 0, 0, 0);
        send(ACT_ORIENT, 0, 0, 0, 0, 0, 0);
        send(ACT_TICK, 0, 0, 0, 0, 0, 16'hFFFF);
        send(ACT_ORIENT, 0, 16'sd16384, 0, 0, 0, 0);
        send(ACT_ORIENT, 0, 16'sd11585, 0, 0, 16'sd11585, 0);
        send(ACT_TICK, 0, 0, 0, 0, 0, 16'h8000);
        send(ACT_ORIENT, 0, -16'sd16384, 16'sd16384, 16'sd16384, -16'sd16384, 0);
        send(ACT_ORIENT, 0, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 0);
        send(ACT_SPEED, 16'sh8000, 0, 0, 0, 0, 0);
        send(ACT_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send(ACT_SPEED, 16'sh7FFF, 0, 0, 0, 0, 0);
        send(ACT_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send(ACT_TICK, 0, 0, 0, 0, 0, 16'hFFFF);
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: begin write_reg(CFG_SPIKE_RATIO, 16'd1023);
                         write_reg(CFG_HEADING_OFFSET, 16'd0); end
                1: begin write_reg(CFG_SPIKE_RATIO, 16'd256);
                         write_reg(CFG_HEADING_OFFSET, 16'hFFFF); end
                2: begin write_reg(CFG_SPIKE_RATIO, 16'hFFFF);
                         write_reg(CFG_HEADING_OFFSET, 16'h8000); end
                default: begin write_reg(CFG_SPIKE_RATIO, 16'($urandom_range(256, 1023)));
                               write_reg(CFG_HEADING_OFFSET, 16'($urandom)); end
            endcase
            repeat (300)
                send_random();
            drain();
        end
        sender_done = 1;
    end

    initial
    begin
        wait (sender_done);
        repeat (40) @(posedge clk);
        $display("Sent %0d requests over 7 register settings; %0d poses compared.",
                 requests_sent, sb.poses_checked);
        if (sb.errors == 0 && sb.pending_poses.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Run timed out.");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
